[hw/rtl/rfalu_pkg.sv]
// Shared types and action codes of the register-file integer ALU.
package rfalu_pkg;

   localparam int WORD_W = 64;
   localparam int ACT_W  = 5;
   localparam int REG_W  = 8;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [ACT_W-1:0]  act_type;

   localparam act_type ACT_ADD     = 5'd0;
   localparam act_type ACT_SUB     = 5'd1;
   localparam act_type ACT_MUL     = 5'd2;
   localparam act_type ACT_DIV     = 5'd3;
   localparam act_type ACT_REM     = 5'd4;
   localparam act_type ACT_NE      = 5'd5;
   localparam act_type ACT_EQ      = 5'd6;
   localparam act_type ACT_LT      = 5'd7;
   localparam act_type ACT_LE      = 5'd8;
   localparam act_type ACT_GT      = 5'd9;
   localparam act_type ACT_GE      = 5'd10;
   localparam act_type ACT_AND     = 5'd11;
   localparam act_type ACT_OR      = 5'd12;
   localparam act_type ACT_XOR     = 5'd13;
   localparam act_type ACT_NOT     = 5'd14;
   localparam act_type ACT_LAND    = 5'd15;
   localparam act_type ACT_LOR     = 5'd16;
   localparam act_type ACT_LNOT    = 5'd17;
   localparam act_type ACT_SHL     = 5'd18;
   localparam act_type ACT_SHR     = 5'd19;
   localparam act_type ACT_NEG     = 5'd20;
   localparam act_type ACT_MOVE    = 5'd21;
   localparam act_type ACT_LOADIMM = 5'd22;

   // Start strobe and operands handed to a multi-cycle unit.
   typedef struct packed {
      logic     start;
      word_type op_a;
      word_type op_b;
   } unit_req_type;

endpackage

[hw/rtl/rfalu_regfile.sv]
// Register file memory with two registered read ports and per-entry valid bits.
module rfalu_regfile #(
   parameter int NUM_REGS = 256,
   parameter int IDX_W    = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr_a,
   input  logic [IDX_W-1:0]     rd_addr_b,
   output rfalu_pkg::word_type  rd_data_a,
   output rfalu_pkg::word_type  rd_data_b,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  rfalu_pkg::word_type  wr_data
);
   import rfalu_pkg::*;

   word_type            mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   word_type            data_a_ff;
   word_type            data_b_ff;
   logic                ok_a_ff;
   logic                ok_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= mem[rd_addr_a];
         data_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ok_a_ff  <= 1'b0;
         ok_b_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            ok_a_ff <= valid_ff[rd_addr_a];
            ok_b_ff <= valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = ok_a_ff ? data_a_ff : '0;
   assign rd_data_b = ok_b_ff ? data_b_ff : '0;

endmodule

[hw/rtl/rfalu_mul.sv]
// Low 64 bits of a 64 by 64 product from one shared 32 by 32 multiplier.
module rfalu_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  rfalu_pkg::unit_req_type  req,
   output rfalu_pkg::word_type      product,
   output logic                     done
);
   import rfalu_pkg::*;

   word_type    a_ff;
   word_type    b_ff;
   word_type    prod_ff;
   word_type    prod_in;
   logic [1:0]  step_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [31:0] mx_a;
   logic [31:0] mx_b;
   logic [63:0] pp;

   always_comb begin
      case (step_ff)
         2'd0: begin
            mx_a = a_ff[31:0];
            mx_b = b_ff[31:0];
         end
         2'd1: begin
            mx_a = a_ff[31:0];
            mx_b = b_ff[63:32];
         end
         default: begin
            mx_a = a_ff[63:32];
            mx_b = b_ff[31:0];
         end
      endcase
      pp = mx_a * mx_b;
      if (step_ff == 2'd0) begin
         prod_in = pp;
      end else begin
         prod_in = {prod_ff[63:32] + pp[31:0], prod_ff[31:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff <= req.op_a;
         b_ff <= req.op_b;
      end
      if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            if (step_ff == 2'd2) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + 2'd1;
         end
      end
   end

   assign product = prod_ff;
   assign done    = done_ff;

endmodule

[hw/rtl/rfalu_div.sv]
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating toward zero.
module rfalu_div (
   input  logic                     clock,
   input  logic                     reset,
   input  rfalu_pkg::unit_req_type  req,
   output rfalu_pkg::word_type      quotient,
   output rfalu_pkg::word_type      remainder,
   output logic                     done
);
   import rfalu_pkg::*;

   word_type    quo_ff;
   word_type    rem_ff;
   word_type    dvs_ff;
   word_type    q_out_ff;
   word_type    r_out_ff;
   logic        neg_q_ff;
   logic        neg_r_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        fix_ff;
   logic        done_ff;
   logic [64:0] trial;
   word_type    abs_a;
   word_type    abs_b;

   assign abs_a = req.op_a[63] ? (64'd0 - req.op_a) : req.op_a;
   assign abs_b = req.op_b[63] ? (64'd0 - req.op_b) : req.op_b;
   assign trial = {rem_ff, quo_ff[63]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff   <= abs_a;
         rem_ff   <= '0;
         dvs_ff   <= abs_b;
         neg_q_ff <= req.op_a[63] ^ req.op_b[63];
         neg_r_ff <= req.op_a[63];
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_ff <= trial[63:0];
         end else begin
            rem_ff <= {rem_ff[62:0], quo_ff[63]};
         end
         quo_ff <= {quo_ff[62:0], ~trial[64]};
      end
      if (fix_ff) begin
         q_out_ff <= neg_q_ff ? (64'd0 - quo_ff) : quo_ff;
         r_out_ff <= neg_r_ff ? (64'd0 - rem_ff) : rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= fix_ff;
         fix_ff  <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd63;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               fix_ff  <= 1'b1;
            end
         end
      end
   end

   assign quotient  = q_out_ff;
   assign remainder = r_out_ff;
   assign done      = done_ff;

endmodule

[hw/rtl/register_file_integer_alu_top.sv]
// Top level: instruction sequencer, combinational ALU and result register.
// One instruction at a time: a beat is taken, both sources are read from the
// register file (a registered read), the result is computed and written back
// while it is loaded into the result register. Multiply runs three steps of
// the shared 32x32 multiplier, divide and remainder 64 steps of the bit-serial
// divider plus sign correction; a zero divisor skips the divider. A result
// waiting on the output does not block the next beat until its own result is
// ready. Register indices at or above NUM_REGS wrap modulo NUM_REGS when
// NUM_REGS is 16 or more. The file reads as zero after reset through
// per-register valid bits, so no clearing pass is needed. Actions 23 to 31
// are taken and dropped without a result.
module register_file_integer_alu_top #(
   parameter int NUM_REGS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [4:0]          req_action,
   input  logic [7:0]          req_src_a,
   input  logic [7:0]          req_src_b,
   input  logic [7:0]          req_dest,
   input  logic signed [63:0]  req_immediate,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [63:0]  rsp_written_value,
   output logic [7:0]          rsp_written_reg,
   output logic                rsp_div_by_zero
);
   import rfalu_pkg::*;

   localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   function automatic logic [IDX_W-1:0] reduce_idx(input logic [7:0] idx);
      logic [11:0] r;
      r = {4'd0, idx};
      for (int k = 3; k >= 0; k--) begin
         if (r >= 12'(NUM_REGS << k)) begin
            r = r - 12'(NUM_REGS << k);
         end
      end
      return r[IDX_W-1:0];
   endfunction

   state_type        state_ff, state_in;
   act_type          act_ff;
   logic [IDX_W-1:0] ia_ff;
   logic [IDX_W-1:0] id_ff;
   word_type         imm_ff;
   word_type         res_ff, res_in;
   logic             dz_ff, dz_in;
   logic [IDX_W-1:0] wa_ff, wa_in;
   logic             rsp_valid_ff;
   word_type         rsp_value_ff;
   logic [7:0]       rsp_reg_ff;
   logic             rsp_dz_ff;

   logic             accept;
   logic             commit;
   logic [IDX_W-1:0] ra_a;
   logic [IDX_W-1:0] ra_b;
   word_type         op_a;
   word_type         op_b;
   logic [5:0]       sh;
   unit_req_type     mul_req;
   unit_req_type     div_req;
   word_type         mul_prod;
   logic             mul_done;
   word_type         div_quo;
   word_type         div_rem;
   logic             div_done;
   logic             lt_ab;
   logic             lt_ba;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign ra_a      = reduce_idx(req_src_a);
   assign ra_b      = reduce_idx(req_src_b);

   rfalu_regfile #(
      .NUM_REGS (NUM_REGS),
      .IDX_W    (IDX_W)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (ra_a),
      .rd_addr_b (ra_b),
      .rd_data_a (op_a),
      .rd_data_b (op_b),
      .wr_en     (commit),
      .wr_addr   (wa_ff),
      .wr_data   (res_ff)
   );

   rfalu_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .product (mul_prod),
      .done    (mul_done)
   );

   rfalu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   assign sh    = op_b[5:0];
   assign lt_ab = $signed(op_a) < $signed(op_b);
   assign lt_ba = $signed(op_b) < $signed(op_a);

   always_comb begin
      state_in      = state_ff;
      res_in        = res_ff;
      dz_in         = dz_ff;
      wa_in         = wa_ff;
      mul_req.start = 1'b0;
      mul_req.op_a  = op_a;
      mul_req.op_b  = op_b;
      div_req.start = 1'b0;
      div_req.op_a  = op_a;
      div_req.op_b  = op_b;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action inside {[ACT_ADD:ACT_LOADIMM]})) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            dz_in    = 1'b0;
            wa_in    = id_ff;
            state_in = ST_DONE;
            case (act_ff)
               ACT_ADD:  res_in = op_a + op_b;
               ACT_SUB:  res_in = op_a - op_b;
               ACT_MUL: begin
                  mul_req.start = 1'b1;
                  state_in      = ST_WAIT;
               end
               ACT_DIV, ACT_REM: begin
                  if (op_b == '0) begin
                     res_in = '0;
                     dz_in  = 1'b1;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = ST_WAIT;
                  end
               end
               ACT_NE:   res_in = {63'd0, op_a != op_b};
               ACT_EQ:   res_in = {63'd0, op_a == op_b};
               ACT_LT:   res_in = {63'd0, lt_ab};
               ACT_LE:   res_in = {63'd0, !lt_ba};
               ACT_GT:   res_in = {63'd0, lt_ba};
               ACT_GE:   res_in = {63'd0, !lt_ab};
               ACT_AND:  res_in = op_a & op_b;
               ACT_OR:   res_in = op_a | op_b;
               ACT_XOR:  res_in = op_a ^ op_b;
               ACT_NOT:  res_in = ~op_a;
               ACT_LAND: res_in = {63'd0, (op_a != '0) && (op_b != '0)};
               ACT_LOR:  res_in = {63'd0, (op_a != '0) || (op_b != '0)};
               ACT_LNOT: res_in = {63'd0, op_a == '0};
               ACT_SHL:  res_in = op_a << sh;
               ACT_SHR:  res_in = word_type'($signed(op_a) >>> sh);
               ACT_NEG: begin
                  res_in = 64'd0 - op_a;
                  wa_in  = ia_ff;
               end
               ACT_MOVE: res_in = op_a;
               default:  res_in = imm_ff;
            endcase
         end
         ST_WAIT: begin
            if (mul_done) begin
               res_in   = mul_prod;
               state_in = ST_DONE;
            end else if (div_done) begin
               res_in   = (act_ff == ACT_DIV) ? div_quo : div_rem;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         ia_ff  <= ra_a;
         id_ff  <= reduce_idx(req_dest);
         imm_ff <= req_immediate;
      end
      res_ff <= res_in;
      dz_ff  <= dz_in;
      wa_ff  <= wa_in;
      if (commit) begin
         rsp_value_ff <= res_ff;
         rsp_reg_ff   <= 8'(wa_ff);
         rsp_dz_ff    <= dz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_written_value = rsp_value_ff;
   assign rsp_written_reg   = rsp_reg_ff;
   assign rsp_div_by_zero   = rsp_dz_ff;

endmodule
